/* rtl/core/e80d_pkg.sv */
// Shared constants, types and helpers for the extended-to-double converter.
package e80d_pkg;

    localparam int EXT_BIAS = 16383;
    localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
    localparam logic [63:0] DBL_INF = 64'h7FF0000000000000;

    // Stage 1 to stage 2: classified, normalized item
    typedef struct packed {
        logic        valid;
        logic        sign;
        logic        force_inf;
        logic        force_zero;
        logic [63:0] norm;     // mantissa shifted so bit 63 is the leading one
        logic signed [17:0] x; // exponent of the leading bit
    } e80d_norm_t;

    // Stage 2 to stage 3: shifted and rounded significand
    typedef struct packed {
        logic        valid;
        logic        sign;
        logic        force_inf;
        logic        force_zero;
        logic [53:0] q;        // rounded significand, may carry to bit 53
        logic signed [17:0] lsb;
    } e80d_round_t;

    // Count leading zeros of a 64-bit word
    function automatic logic [5:0] clz64(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 6'(63 - i);
            end
        end
        return n;
    endfunction

endpackage

/* rtl/core/e80d_normalize.sv */
// Stage 1: classify the input and normalize the mantissa.
module e80d_normalize (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [15:0]          sign_and_exponent,
    input  logic [63:0]          mantissa,
    output e80d_pkg::e80d_norm_t norm_reg
);
    import e80d_pkg::*;

    e80d_norm_t norm_next;
    logic [5:0] lz;

    // Find leading bit, build exponent of that bit
    always_comb
    begin
        lz = clz64(mantissa);
        norm_next.valid = in_valid;
        norm_next.sign = sign_and_exponent[15];
        norm_next.force_inf = (sign_and_exponent[14:0] == EXT_EXP_MAX);
        norm_next.force_zero = (mantissa == 64'd0) || (sign_and_exponent[14:0] == 15'd0);
        norm_next.norm = mantissa << lz;
        norm_next.x = 18'($signed({3'b000, sign_and_exponent[14:0]}))
                      - 18'(EXT_BIAS) - 18'($signed({12'd0, lz}));
    end

    // Clear valid under reset, advance the word otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            norm_reg.valid <= 1'b0;
        end else begin
            norm_reg <= norm_next;
        end
    end
endmodule

/* rtl/core/e80d_round.sv */
// Stage 2: align to the double grid and round to nearest even.
module e80d_round (
    input  logic                  clk,
    input  logic                  rst_n,
    input  e80d_pkg::e80d_norm_t  norm_reg,
    output e80d_pkg::e80d_round_t rnd_reg
);
    import e80d_pkg::*;

    e80d_round_t rnd_next;
    logic signed [17:0] lsb;
    logic [17:0] sh;     // right shift of the normalized word, 11 for normal
    logic [6:0]  shc;
    logic [127:0] wide;
    logic [52:0] q;
    logic        rbit;
    logic        sticky;
    logic        ovf;

    // Subnormal results drop extra bits beyond the normal 11
    always_comb
    begin
        ovf = (norm_reg.x > 18'sd1023);
        if (norm_reg.x < -18'sd1022) begin
            lsb = -18'sd1074;
            sh = 18'(-18'sd1022 - norm_reg.x + 18'sd11);
        end else begin
            lsb = norm_reg.x - 18'sd52;
            sh = 18'd11;
        end
        shc = (sh > 18'd65) ? 7'd65 : sh[6:0];
        wide = {norm_reg.norm, 64'd0} >> shc;
        q = wide[116:64];
        rbit = wide[63];
        sticky = (wide[62:0] != 63'd0);
        rnd_next.valid = norm_reg.valid;
        rnd_next.sign = norm_reg.sign;
        rnd_next.force_inf = norm_reg.force_inf || (ovf && !norm_reg.force_zero);
        rnd_next.force_zero = norm_reg.force_zero;
        rnd_next.q = {1'b0, q} + 54'(rbit && (sticky || q[0]));
        rnd_next.lsb = lsb;
    end

    // Clear valid under reset, advance the word otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rnd_reg.valid <= 1'b0;
        end else begin
            rnd_reg <= rnd_next;
        end
    end
endmodule

/* rtl/core/e80d_pack.sv */
// Stage 3: renormalize after rounding and pack the double word.
module e80d_pack (
    input  logic                  clk,
    input  logic                  rst_n,
    input  e80d_pkg::e80d_round_t rnd_reg,
    output logic                  done_reg,
    output logic [63:0]           bits_reg
);
    import e80d_pkg::*;

    logic [52:0] q;
    logic signed [17:0] lsb;
    logic signed [17:0] field;
    logic [63:0] bits_next;

    // Renormalize on a rounding carry, then build exponent field and pack the word
    always_comb
    begin
        if (rnd_reg.q[53]) begin
            q = rnd_reg.q[53:1];
            lsb = rnd_reg.lsb + 18'sd1;
        end else begin
            q = rnd_reg.q[52:0];
            lsb = rnd_reg.lsb;
        end
        field = lsb + 18'sd1075;
        if (rnd_reg.force_inf) begin
            bits_next = {rnd_reg.sign, DBL_INF[62:0]};
        end else if (rnd_reg.force_zero) begin
            bits_next = {rnd_reg.sign, 63'd0};
        end else if (!q[52]) begin
            bits_next = {rnd_reg.sign, 11'd0, q[51:0]};
        end else if (field >= 18'sd2047) begin
            bits_next = {rnd_reg.sign, DBL_INF[62:0]};
        end else begin
            bits_next = {rnd_reg.sign, field[10:0], q[51:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= rnd_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end
endmodule

/* rtl/core/extended80_to_double_convert.sv */
// Pipeline: start passes through the normalize, round and pack stage registers before done.
// Throughput: one word per cycle; busy is always low, the pipeline never stalls.
// The receiver cannot stall: done is high for exactly one cycle per word.
// Reset: rst_n clears all stage valid bits asynchronously; no word is in flight after it.
// Top level: extended 80-bit to binary64 converter.
module extended80_to_double_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] sign_and_exponent,
    input  logic [63:0] mantissa,
    output logic        done,
    output logic [63:0] double_bits
);
    import e80d_pkg::*;

    e80d_norm_t  norm_reg;
    e80d_round_t rnd_reg;
    logic        done_reg;
    logic [63:0] bits_reg;

    assign busy = 1'b0;

    e80d_normalize u_norm (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .sign_and_exponent(sign_and_exponent), .mantissa(mantissa),
        .norm_reg(norm_reg)
    );

    e80d_round u_round (.clk(clk), .rst_n(rst_n), .norm_reg(norm_reg), .rnd_reg(rnd_reg));

    e80d_pack u_pack (
        .clk(clk), .rst_n(rst_n), .rnd_reg(rnd_reg),
        .done_reg(done_reg), .bits_reg(bits_reg)
    );

    assign done = done_reg;
    assign double_bits = bits_reg;

    // Valid bits walk the pipeline in order
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done) else $error("word lost in pipeline");
    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg.valid |=> done) else $error("done missing after round stage");
    a_normlead: assert property (@(posedge clk) disable iff (!rst_n)
        (norm_reg.valid && !norm_reg.force_zero) |-> norm_reg.norm[63])
        else $error("normalize lost leading one");
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg.valid |=> (double_bits[63] == $past(rnd_reg.sign)))
        else $error("sign not kept");
endmodule

/* tb/sv/extended80_to_double_convert_tb.sv */
// Testbench for the extended-to-double converter: directed table, then random words.
module extended80_to_double_convert_tb;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] sign_and_exponent;
    logic [63:0] mantissa;
    logic        done;
    logic [63:0] double_bits;

    localparam logic [63:0] DBL_FRAC = 64'h000FFFFFFFFFFFFF;
    localparam logic [63:0] DBL_HID  = 64'h0010000000000000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 1800;
    localparam int N_DIRECTED = 20;

    typedef struct {
        logic [15:0] se;
        logic [63:0] m;
        bit          known;
        logic [63:0] want;
    } stim_row_t;

    stim_row_t   table_rows [N_DIRECTED];
    logic [63:0] pending_doubles [$];
    int          n_errors;
    int          table_errors;
    int          idle_cycles;

    extended80_to_double_convert dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sign_and_exponent(sign_and_exponent), .mantissa(mantissa),
        .done(done), .double_bits(double_bits)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Compute the rounded binary64 pattern of one extended word
    function automatic logic [63:0] to_double(input logic [15:0] se, input logic [63:0] m);
        logic [63:0] sgn;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int e, scale, p, x, lsb, s, fld;
        sgn = se[15] ? {1'b1, 63'd0} : 64'd0;
        e = int'(se[14:0]);
        if (e == int'(e80d_pkg::EXT_EXP_MAX))
            return sgn | e80d_pkg::DBL_INF;
        if (m == 64'd0)
            return sgn;
        scale = e - e80d_pkg::EXT_BIAS - 63;
        p = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (m[i])
                p = i;
        end
        x = p + scale;
        if (x > 1023)
            return sgn | e80d_pkg::DBL_INF;
        lsb = x - 52;
        if (lsb < -1074)
            lsb = -1074;
        s = lsb - scale;
        if (s <= 0)
            q = m << (-s);
        else if (s > 64)
            return sgn;
        else
        begin
            if (s == 64)
            begin
                q = 64'd0;
                rem = m;
            end
            else
            begin
                q = m >> s;
                rem = m & ((64'd1 << s) - 64'd1);
            end
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
        end
        if (q >= (DBL_HID << 1))
        begin
            q = q >> 1;
            lsb++;
        end
        if (q < DBL_HID)
            return sgn | q;
        fld = lsb + 1075;
        if (fld >= 2047)
            return sgn | e80d_pkg::DBL_INF;
        return sgn | (64'(fld) << 52) | (q & DBL_FRAC);
    endfunction

    // Build a random word: mostly in or near double range, some anywhere
    task automatic random_word(output logic [15:0] se, output logic [63:0] m);
        int r;
        int ex;
        r = $urandom_range(0, 99);
        m = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            m = m >> $urandom_range(0, 63);
        else
            m[63] = 1'b1;
        if (r < 40)
            ex = 16383 + $urandom_range(0, 2100) - 1050;
        else if (r < 60)
            ex = 16383 - 1022 - $urandom_range(0, 130);
        else if (r < 75)
            ex = 16383 + 1020 + $urandom_range(0, 8);
        else if (r < 80)
            ex = $urandom_range(0, 1) ? 0 : 32767;
        else
            ex = $urandom_range(0, 32767);
        se = {1'($urandom), 15'(ex)};
        // Push ties and carry-overs at times
        if (r % 7 == 0)
            m[10:0] = 11'h400;
        if (r % 11 == 0)
            m[62:0] = {63{1'b1}};
    endtask

    // Offer one word, idling at random, and queue its expected double
    task automatic send_word(input logic [15:0] se, input logic [63:0] m, input bit quiet);
        while (!quiet && $urandom_range(0, 99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sign_and_exponent <= se;
        mantissa <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_doubles.push_back(to_double(se, m));
    endtask

    // Check each done word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_doubles.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, double_bits);
                n_errors++;
            end
            else
            begin
                if (double_bits !== pending_doubles[0])
                begin
                    $display("%0t: double_bits mismatch, expected %h, actual %h",
                             $time, pending_doubles[0], double_bits);
                    n_errors++;
                end
                void'(pending_doubles.pop_front());
            end
        end
    end

    // Watchdog on cycles with no accepted word and no done
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] se;
        logic [63:0] m;
        table_errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sign_and_exponent = 16'd0;
        mantissa = 64'd0;

        table_rows[0]  = '{16'h3FFF, 64'h8000000000000000, 1, 64'h3FF0000000000000};
        table_rows[1]  = '{16'hBFFF, 64'h8000000000000000, 1, 64'hBFF0000000000000};
        table_rows[2]  = '{16'h7FFF, 64'hC000000000000001, 1, 64'h7FF0000000000000};
        table_rows[3]  = '{16'hFFFF, 64'h0000000000000000, 1, 64'hFFF0000000000000};
        table_rows[4]  = '{16'h4000, 64'h0000000000000000, 1, 64'h0000000000000000};
        table_rows[5]  = '{16'h8123, 64'h0000000000000000, 1, 64'h8000000000000000};
        table_rows[6]  = '{16'h0000, 64'hFFFFFFFFFFFFFFFF, 1, 64'h0000000000000000};
        table_rows[7]  = '{16'h8000, 64'h0000000000000001, 1, 64'h8000000000000000};
        table_rows[8]  = '{16'h7FFE, 64'hFFFFFFFFFFFFFFFF, 1, 64'h7FF0000000000000};
        table_rows[9]  = '{16'h43FE, 64'hFFFFFFFFFFFFFC00, 1, 64'h7FF0000000000000};
        table_rows[10] = '{16'h43FE, 64'hFFFFFFFFFFFFF7FF, 0, 64'd0};
        table_rows[11] = '{16'h3C01, 64'h8000000000000000, 0, 64'd0};
        table_rows[12] = '{16'h3C00, 64'h8000000000000000, 0, 64'd0};
        table_rows[13] = '{16'h3BCD, 64'h8000000000000000, 0, 64'd0};
        table_rows[14] = '{16'h3BCC, 64'h8000000000000000, 0, 64'd0};
        table_rows[15] = '{16'h3BCC, 64'h8000000000000001, 0, 64'd0};
        table_rows[16] = '{16'h3FFF, 64'h8000000000000400, 0, 64'd0};
        table_rows[17] = '{16'h3FFF, 64'h8000000000000C00, 0, 64'd0};
        table_rows[18] = '{16'h403E, 64'h0000000000000003, 0, 64'd0};
        table_rows[19] = '{16'h3C00, 64'hFFFFFFFFFFFFFFFF, 0, 64'd0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (table_rows[i])
        begin
            if (table_rows[i].known &&
                to_double(table_rows[i].se, table_rows[i].m) !== table_rows[i].want)
            begin
                $display("%0t: table row %0d, expected %h, actual %h", $time, i,
                         table_rows[i].want, to_double(table_rows[i].se, table_rows[i].m));
                table_errors++;
            end
            send_word(table_rows[i].se, table_rows[i].m, 1'b0);
        end

        // Random words, with a back-to-back stretch in the middle
        for (int k = 0; k < N_RANDOM; k++)
        begin
            random_word(se, m);
            send_word(se, m, (k >= 600 && k < 900));
        end
        start <= 1'b0;

        // Drain and allow for pipeline latency
        while (pending_doubles.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_errors == 0 && table_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* extended80_to_double_convert.f */
rtl/core/e80d_pkg.sv
rtl/core/e80d_normalize.sv
rtl/core/e80d_round.sv
rtl/core/e80d_pack.sv
rtl/core/extended80_to_double_convert.sv
tb/sv/extended80_to_double_convert_tb.sv
